// ===== sv/vbd_pkg.sv =====
// Types and constants shared by the varint byte decoder modules.
package vbd_pkg;

    // decode_mode register codes; the spare code decodes as unsigned
    localparam logic [1:0] MODE_UNSIGNED = 2'd0;
    localparam logic [1:0] MODE_SIGNED   = 2'd1;
    localparam logic [1:0] MODE_PACKED   = 2'd2;

    // register index of decode_mode
    localparam logic REG_DECODE_MODE = 1'b0;

    // APB address width: bit 2 selects the register word
    localparam int ADDR_W = 3;

    // 7-bit group index: groups sit at bit 0, 7, 14, 21, 28, then saturate
    localparam int GRP_W = 3;
    localparam logic [GRP_W-1:0] GRP_0    = 3'd0;
    localparam logic [GRP_W-1:0] GRP_1    = 3'd1;
    localparam logic [GRP_W-1:0] GRP_2    = 3'd2;
    localparam logic [GRP_W-1:0] GRP_3    = 3'd3;
    localparam logic [GRP_W-1:0] GRP_TOP  = 3'd4;  // slice at bit 28
    localparam logic [GRP_W-1:0] GRP_OVER = 3'd5;  // slices past bit 31

    // decode state carried from byte to byte
    typedef struct packed {
        logic [31:0]      value;
        logic [GRP_W-1:0] grp;
        logic             ovf;
    } dec_state_t;

    // result of one byte step
    typedef struct packed {
        dec_state_t  next;
        logic        done;
        logic [31:0] value;
        logic        ovf;
    } step_out_t;

endpackage

// ===== sv/varint_byte_decoder.sv =====
// Top level of the varint byte decoder: state, result register and APB register.
//
// Decodes 32-bit variable-length integers from a byte stream, one byte beat
// per clock. decode_mode (APB address 0) selects unsigned LEB128 (0, and the
// spare code 3), signed LEB128 (1) or packed most-significant-group-first (2).
// Each accepted byte is folded into the running value by one level of logic
// between the state registers and the result register, so a new byte is taken
// every cycle; a byte with bit 7 clear ends the number and its value and
// overflow flag appear on the output in the cycle after that byte is accepted.
// The result register is reloaded in the same cycle it is read, so input keeps
// flowing at one byte per cycle while out_ready is high; input stalls, for any
// byte, only while a finished result is held and out_ready is low. Bits beyond
// 31 are dropped; the LEB128 modes flag them in overflow_flag, packed mode
// never does. A decode_mode write applies from the next byte, even within a
// number; overflow already flagged for that number stays flagged.
module varint_byte_decoder
    import vbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        code_byte,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       decoded_value,
    output logic              overflow_flag
);

    logic [1:0]  mode_reg;
    dec_state_t  state_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic        ovf_reg;
    step_out_t   step;
    logic        in_fire;
    logic        cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DECODE_MODE);
    assign prdata = (paddr[2] == REG_DECODE_MODE) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_UNSIGNED;
        else if (cfg_wr)
            mode_reg <= pwdata[1:0];
    end

    // byte datapath
    vbd_step u_step
    (
        .mode      (mode_reg),
        .code_byte (code_byte),
        .cur       (state_reg),
        .res       (step)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // running decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_fire)
            state_reg <= step.next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && step.done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step.done)
        begin
            value_reg <= step.value;
            ovf_reg   <= step.ovf;
        end
    end

    assign out_valid     = out_valid_reg;
    assign decoded_value = value_reg;
    assign overflow_flag = ovf_reg;

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !code_byte[7]) |=> out_valid_reg)
        else $error("final byte did not produce a result");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !code_byte[7]) |=>
            (state_reg.grp == GRP_0 && !state_reg.ovf && state_reg.value == 32'd0))
        else $error("decode state not cleared after a number");

    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.grp <= GRP_OVER)
        else $error("group index past saturation");

endmodule

// ===== sv/vbd_step.sv =====
// Combinational decode of one byte against the running varint state.
module vbd_step
    import vbd_pkg::*;
(
    input  logic [1:0]  mode,
    input  logic [7:0]  code_byte,
    input  dec_state_t  cur,
    output step_out_t   res
);

    logic [6:0]  slice;
    logic        more;
    logic [31:0] placed;
    logic [31:0] ext_mask;
    logic [31:0] val_acc;
    logic        ovf_acc;
    logic        ovf_uns;
    logic        ovf_sgn;
    logic [GRP_W-1:0] grp_inc;

    assign slice = code_byte[6:0];
    assign more  = code_byte[7];

    // slice placed at its LEB128 position, and the sign fill above this group
    always_comb
    begin
        unique case (cur.grp)
            GRP_0:
            begin
                placed   = {25'd0, slice};
                ext_mask = {{25{1'b1}}, 7'd0};
            end
            GRP_1:
            begin
                placed   = {18'd0, slice, 7'd0};
                ext_mask = {{18{1'b1}}, 14'd0};
            end
            GRP_2:
            begin
                placed   = {11'd0, slice, 14'd0};
                ext_mask = {{11{1'b1}}, 21'd0};
            end
            GRP_3:
            begin
                placed   = {4'd0, slice, 21'd0};
                ext_mask = {{4{1'b1}}, 28'd0};
            end
            GRP_TOP:
            begin
                placed   = {slice[3:0], 28'd0};
                ext_mask = 32'd0;
            end
            default:
            begin
                placed   = 32'd0;
                ext_mask = 32'd0;
            end
        endcase
    end

    // overflow checks on the top group and on anything past it
    always_comb
    begin
        ovf_uns = 1'b0;
        ovf_sgn = 1'b0;
        if (cur.grp == GRP_TOP)
        begin
            ovf_uns = |slice[6:4];
            ovf_sgn = (slice[6:3] != 4'h0) && (slice[6:3] != 4'hf);
        end
        else if (cur.grp == GRP_OVER)
        begin
            ovf_uns = |slice;
            ovf_sgn = slice != (cur.value[31] ? 7'h7f : 7'h00);
        end
    end

    // value and sticky overflow after this byte, per mode
    always_comb
    begin
        unique case (mode)
            MODE_PACKED:
            begin
                val_acc = {cur.value[24:0], slice};
                ovf_acc = cur.ovf;
            end
            MODE_SIGNED:
            begin
                val_acc = cur.value | placed
                        | ((!more && code_byte[6]) ? ext_mask : 32'd0);
                ovf_acc = cur.ovf | ovf_sgn;
            end
            default:
            begin
                val_acc = cur.value | placed;
                ovf_acc = cur.ovf | ovf_uns;
            end
        endcase
    end

    // group index saturates once past bit 31
    assign grp_inc = (cur.grp == GRP_OVER) ? GRP_OVER : cur.grp + GRP_W'(1);

    // a final byte emits and clears the state
    always_comb
    begin
        res.done  = !more;
        res.value = val_acc;
        res.ovf   = ovf_acc;
        if (more)
        begin
            res.next.value = val_acc;
            res.next.grp   = grp_inc;
            res.next.ovf   = ovf_acc;
        end
        else
        begin
            res.next.value = 32'd0;
            res.next.grp   = GRP_0;
            res.next.ovf   = 1'b0;
        end
    end

endmodule
